// File: rtl/core/csr_sparse_matvec_assert.svh
// assertion macros used by the checker
`ifndef CSR_SPARSE_MATVEC_ASSERT_SVH
`define CSR_SPARSE_MATVEC_ASSERT_SVH

// same-cycle implication
`define CSM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csm check failed");

// next-cycle implication
`define CSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csm check failed");

`endif

// File: rtl/core/csm_pkg.sv
package csm_pkg;

	localparam int SLOT_W = 10;
	localparam int ACC_W = 64;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_MAC   = 2'd1,
		CMD_CLOSE = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [SLOT_W-1:0]  slot;
		logic signed [31:0] operand;
	} item_t;

	typedef struct packed {
		logic [15:0]        row_index;
		logic signed [31:0] row_sum;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic add;
		logic close;
	} acc_ctl_t;

endpackage

// File: rtl/core/csm_vec_store.sv
module csm_vec_store #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/core/csm_accum.sv
module csm_accum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csm_pkg::acc_ctl_t     ctl,
	input  logic signed [63:0]    product,
	output csm_pkg::result_t      row
);

	import csm_pkg::*;

	logic signed [ACC_W-1:0] acc_q;
	logic                    clip_q;
	logic [15:0]             cnt_q;
	logic [ACC_W:0]          sum;
	logic                    ovf;
	logic [ACC_W-1:0]        sat_sum;
	logic [47:0]             shifted;
	logic                    pos_clip;
	logic                    neg_clip;

	// 65-bit sum, clip to the 64-bit limits
	assign sum = {acc_q[ACC_W-1], acc_q} + {product[63], product};
	assign ovf = sum[ACC_W] != sum[ACC_W-1];

	always_comb begin
		if (!ovf) begin
			sat_sum = sum[ACC_W-1:0];
		end else if (sum[ACC_W]) begin
			sat_sum = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			sat_sum = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	// q32.32 to q16.16 by floor, then clip to 32 bits
	assign shifted = acc_q[ACC_W-1:16];
	assign pos_clip = !shifted[47] && (|shifted[46:31]);
	assign neg_clip = shifted[47] && !(&shifted[46:31]);

	always_comb begin
		row.row_index = cnt_q;
		row.saturated = clip_q || pos_clip || neg_clip;
		if (pos_clip) begin
			row.row_sum = 32'sh7fffffff;
		end else if (neg_clip) begin
			row.row_sum = 32'sh80000000;
		end else begin
			row.row_sum = shifted[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			clip_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.close) begin
			acc_q <= '0;
			clip_q <= 1'b0;
			cnt_q <= cnt_q + 16'd1;
		end else if (ctl.add) begin
			acc_q <= sat_sum;
			clip_q <= clip_q | ovf;
		end
	end

endmodule

// File: rtl/core/csr_sparse_matvec.sv
// sparse matrix times dense vector, matrix streamed in compressed-row order
// input channel item (valid/stall) carries cmd, slot and operand:
//   load     writes operand into vector element slot
//   nonzero  adds operand * x[slot] to the running row sum (q32.32)
//   close    emits one word on the result channel and starts the next row
// result channel result (valid/stall) carries row_index, row_sum, saturated
// one item is taken every cycle while item_stall is low; the vector store has one write port and
// one read port, so a load and a nonzero read go side by side
// a close word reaches result through stage s1, stage s2 and the result register
// loads and nonzeros flow on while a result waits; only a close that meets
// a full, stalled result register holds the pipeline and raises item_stall
// reset clears the pipeline, the row sum, the clip flag and the row number;
// vector contents are undefined until loaded
module csr_sparse_matvec #(
	parameter int VECTOR_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  csm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output csm_pkg::result_t result
);

	import csm_pkg::*;

	localparam int AW = $clog2(VECTOR_DEPTH);

	logic               adv;
	logic               accept;
	logic               in_range;
	logic [AW+SLOT_W-1:0] slot_ext;
	logic [AW-1:0]      addr;
	logic [31:0]        rd_data;

	logic               valid_s1;
	logic [1:0]         cmd_s1;
	logic               range_s1;
	logic signed [31:0] operand_s1;
	logic signed [31:0] x_s1;
	logic signed [63:0] prod;

	logic               valid_s2;
	logic [1:0]         cmd_s2;
	logic signed [63:0] prod_s2;

	acc_ctl_t           ctl;
	result_t            row;
	logic               out_valid_q;
	result_t            result_q;

	assign adv = !(valid_s2 && cmd_s2 == CMD_CLOSE && out_valid_q && result_stall);
	assign item_stall = !adv;
	assign accept = item_valid && adv;

	assign in_range = {{(32-SLOT_W){1'b0}}, item.slot} < 32'(VECTOR_DEPTH);
	assign slot_ext = (AW+SLOT_W)'(item.slot);
	assign addr = slot_ext[AW-1:0];

	csm_vec_store #(
		.DEPTH(VECTOR_DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.wr_en(accept && item.cmd == CMD_LOAD && in_range),
		.wr_addr(addr),
		.wr_data(item.operand),
		.rd_en(accept && item.cmd == CMD_MAC),
		.rd_addr(addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= item.cmd;
			range_s1 <= in_range;
			operand_s1 <= item.operand;
			cmd_s2 <= cmd_s1;
			prod_s2 <= prod;
		end
	end

	// column beyond the store contributes zero
	assign x_s1 = range_s1 ? rd_data : 32'sd0;
	assign prod = operand_s1 * x_s1;

	assign ctl.add = adv && valid_s2 && cmd_s2 == CMD_MAC;
	assign ctl.close = adv && valid_s2 && cmd_s2 == CMD_CLOSE;

	csm_accum u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.product(prod_s2),
		.row(row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.close) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.close) begin
			result_q <= row;
		end
	end

	assign result_valid = out_valid_q;
	assign result = result_q;

endmodule

// File: rtl/core/csm_checker.sv
`include "csr_sparse_matvec_assert.svh"

module csm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input csm_pkg::result_t result
);

	import csm_pkg::*;

	logic        seen_q;
	logic [15:0] last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			last_q <= '0;
		end else if (result_valid && !result_stall) begin
			seen_q <= 1'b1;
			last_q <= result.row_index;
		end
	end

	// input held back only by a close behind a stalled result word
	`CSM_ASSERT_NOW(stall_cause, item_stall, result_valid && result_stall)

	// rows come out numbered one after another
	`CSM_ASSERT_NOW(row_order, result_valid && !result_stall && seen_q, result.row_index == 16'(last_q + 16'd1))

	`CSM_ASSERT_NEXT(valid_held, result_valid && result_stall, result_valid)

	`CSM_ASSERT_NEXT(word_held, result_valid && result_stall, $stable(result))

endmodule

bind csr_sparse_matvec csm_checker u_csm_checker (.*);
